[rtl/length_prefixed_word_block_deframer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed word block deframer
// Shared forms for the concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_WORD_BLOCK_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_WORD_BLOCK_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPWD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lpwd_pkg.sv]
// ----------------------------------------------------------------------------
// lpwd_pkg
// Types and codes shared by the deframer's front end, queue and back end.
// ----------------------------------------------------------------------------
package lpwd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 2;

  // Input opcodes.
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // Result kinds as they appear on the kind port.
  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  // One classified event from the front end, waiting for the back end.
  typedef struct packed {
    kind_t              kind;
    logic [WordW-1:0]   word;
    logic               last;
  } evt_t;

endpackage

[rtl/length_prefixed_word_block_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_word_block_deframer
// Turns a byte stream of count-prefixed word blocks into indexed word results.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one transaction per stream byte (opcode data) or
// a peer-close event (opcode close); one transaction per clock unless stalled.
// Each block starts with a four-byte big-endian word count and is followed by
// that many 32-bit words, assembled little- or big-endian as cfg_wr_data set.
// The output channel returns one transaction for each finished word, for each
// zero count (end of transmission, with the committed total) and for each
// close (abort, with the committed total). Other bytes give no transaction.
// Throughput is one byte per cycle while in_stall is low.
// A two-entry event queue and the output register part the sides: when the
// receiver stalls, up to three results are held and in_stall rises only when
// the queue is full. rst is synchronous and clears the control state and the
// byte order register (little-endian), but not queue entries or the payload.
// ----------------------------------------------------------------------------
module length_prefixed_word_block_deframer (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [lpwd_pkg::ByteW-1:0]  rx_byte,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [lpwd_pkg::WordW-1:0]  word_value,
  output logic [lpwd_pkg::WordW-1:0]  element_index,
  output logic                        block_last,
  output logic [lpwd_pkg::WordW-1:0]  total_elements
);
  import lpwd_pkg::*;

  logic  big_endian;
  logic  in_fire;
  logic  push;
  evt_t  push_evt;
  logic  q_full;
  logic  q_not_empty;
  evt_t  q_head;
  logic  pop;
  kind_t out_kind;

  // Byte order register; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
    end else if (cfg_wr_en) begin
      big_endian <= cfg_wr_data;
    end
  end

  // The front end never pushes more than one event per byte, so the input
  // need only hold off while the queue has no free entry.
  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  lpwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .opcode     (opcode),
    .rx_byte    (rx_byte),
    .big_endian (big_endian),
    .push       (push),
    .push_evt   (push_evt)
  );

  lpwd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_evt  (push_evt),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The back end holds the running totals, so the element index of each
  // word follows the events in queue order.
  lpwd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (q_not_empty),
    .evt       (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_word  (word_value),
    .out_index (element_index),
    .out_last  (block_last),
    .out_total (total_elements)
  );

  assign kind = out_kind;

endmodule

[rtl/lpwd_front.sv]
// ----------------------------------------------------------------------------
// lpwd_front
// Byte assembler: builds headers and payload words and classifies events.
// ----------------------------------------------------------------------------
module lpwd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         opcode,
  input  logic [lpwd_pkg::ByteW-1:0]   rx_byte,
  input  logic                         big_endian,
  output logic                         push,
  output lpwd_pkg::evt_t               push_evt
);
  import lpwd_pkg::*;

  logic              in_payload, in_payload_next;
  logic [PhaseW-1:0] byte_phase, byte_phase_next;
  logic [WordW-1:0]  assembly, assembly_next;
  logic [WordW-1:0]  words_left, words_left_next;
  logic [WordW-1:0]  shifted;
  logic              phase_done;

  assign phase_done = (byte_phase == {PhaseW{1'b1}});

  always_comb begin
    if (!in_payload || big_endian) begin
      shifted = {assembly[WordW-ByteW-1:0], rx_byte};
    end else begin
      shifted = {rx_byte, assembly[WordW-1:ByteW]};
    end
  end

  always_comb begin
    in_payload_next = in_payload;
    byte_phase_next = byte_phase;
    assembly_next   = assembly;
    words_left_next = words_left;
    push            = 1'b0;
    push_evt.kind   = KIND_WORD;
    push_evt.word   = '0;
    push_evt.last   = 1'b0;
    if (fire) begin
      if (opcode == OP_CLOSE) begin
        push            = 1'b1;
        push_evt.kind   = KIND_ABORT;
        in_payload_next = 1'b0;
        byte_phase_next = '0;
        assembly_next   = '0;
        words_left_next = '0;
      end else begin
        byte_phase_next = byte_phase + PhaseW'(1);
        assembly_next   = shifted;
        if (phase_done) begin
          assembly_next = '0;
          if (!in_payload) begin
            if (shifted == '0) begin
              push          = 1'b1;
              push_evt.kind = KIND_END;
            end else begin
              in_payload_next = 1'b1;
              words_left_next = shifted;
            end
          end else begin
            push            = 1'b1;
            push_evt.kind   = KIND_WORD;
            push_evt.word   = shifted;
            push_evt.last   = (words_left == WordW'(1));
            words_left_next = words_left - WordW'(1);
            if (words_left == WordW'(1)) begin
              in_payload_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      byte_phase <= '0;
      assembly   <= '0;
      words_left <= '0;
    end else begin
      in_payload <= in_payload_next;
      byte_phase <= byte_phase_next;
      assembly   <= assembly_next;
      words_left <= words_left_next;
    end
  end

endmodule

[rtl/lpwd_queue.sv]
// ----------------------------------------------------------------------------
// lpwd_queue
// Two-entry event queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lpwd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lpwd_pkg::evt_t  push_evt,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lpwd_pkg::evt_t  head
);
  import lpwd_pkg::*;

  evt_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/lpwd_back.sv]
// ----------------------------------------------------------------------------
// lpwd_back
// Result builder: keeps the element totals and drives the output register.
// ----------------------------------------------------------------------------
module lpwd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        evt_valid,
  input  lpwd_pkg::evt_t              evt,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lpwd_pkg::kind_t             out_kind,
  output logic [lpwd_pkg::WordW-1:0]  out_word,
  output logic [lpwd_pkg::WordW-1:0]  out_index,
  output logic                        out_last,
  output logic [lpwd_pkg::WordW-1:0]  out_total
);
  import lpwd_pkg::*;

  logic [WordW-1:0] committed;
  logic [WordW-1:0] done_in_block;
  logic [WordW-1:0] index;

  assign pop   = evt_valid && (!out_valid || !out_stall);
  assign index = committed + done_in_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      committed     <= '0;
      done_in_block <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (evt.kind)
          KIND_WORD: begin
            if (evt.last) begin
              committed     <= index + WordW'(1);
              done_in_block <= '0;
            end else begin
              done_in_block <= done_in_block + WordW'(1);
            end
          end
          KIND_END: begin
            committed <= '0;
          end
          KIND_ABORT: begin
            committed     <= '0;
            done_in_block <= '0;
          end
          default: begin
            committed <= committed;
          end
        endcase
      end
    end
  end

  // Result payload; only meaningful while out_valid is high.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= evt.kind;
      if (evt.kind == KIND_WORD) begin
        out_word  <= evt.word;
        out_index <= index;
        out_last  <= evt.last;
        out_total <= '0;
      end else begin
        out_word  <= '0;
        out_index <= '0;
        out_last  <= 1'b0;
        out_total <= committed;
      end
    end
  end

endmodule

[rtl/lpwd_checker.sv]
// ----------------------------------------------------------------------------
// lpwd_checker
// Port-level checks on the deframer's output transactions.
// ----------------------------------------------------------------------------
`include "length_prefixed_word_block_deframer_assert.svh"

module lpwd_checker (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_stall,
  input logic [1:0]   kind,
  input logic [31:0]  word_value,
  input logic [31:0]  element_index,
  input logic         block_last,
  input logic [31:0]  total_elements
);
  import lpwd_pkg::*;

  logic kind_known;
  logic is_word;

  assign kind_known = (kind == KIND_WORD) || (kind == KIND_END) || (kind == KIND_ABORT);
  assign is_word    = (kind == KIND_WORD);

  `LPWD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(word_value) && $stable(element_index), "stalled output transaction changed")
  `LPWD_ASSERT_SAME(a_kind_legal, out_valid, kind_known, "unused result kind")
  `LPWD_ASSERT_SAME(a_ctrl_fields, out_valid && !is_word, word_value == '0 && element_index == '0 && !block_last, "word fields set on end or abort")
  `LPWD_ASSERT_SAME(a_word_total, out_valid && is_word, total_elements == '0, "total set on a payload word")

endmodule

bind length_prefixed_word_block_deframer lpwd_checker u_lpwd_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for length_prefixed_word_block_deframer
// Drives byte streams of count-prefixed word blocks, peer-close events and
// byte order changes into the deframer. A predictor kept in step with the
// accepted bytes queues the results it expects, and every result that leaves
// the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import lpwd_pkg::*;

  // The run is stopped if no transaction moves on either channel for this
  // many cycles. The longest legal quiet stretch is the receiver hold-off.
  localparam int unsigned QuietLimit = 4000;
  // Cycles allowed after the last awaited result for header bytes, which
  // give no result, to work their way through the pipeline.
  localparam int unsigned SettleCycles = 4;
  // Only the first mismatches are printed; all of them are counted.
  localparam int unsigned MaxPrinted = 40;

  typedef struct {
    kind_t       kind;
    logic [31:0] word;
    logic [31:0] elem_index;
    logic        blk_last;
    logic [31:0] total;
  } deframe_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_DATA;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] word_value;
  logic [31:0] element_index;
  logic        block_last;
  logic [31:0] total_elements;

  // Predictor state, mirroring the deframer after every accepted transaction.
  logic        order_be = 1'b0;
  logic        in_block = 1'b0;
  logic [1:0]  phase = 2'd0;
  logic [31:0] assembly = '0;
  logic [31:0] words_left = '0;
  logic [31:0] words_done = '0;
  logic [31:0] total_committed = '0;

  deframe_result_t awaited_results[$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned long_hold = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  length_prefixed_word_block_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .word_value     (word_value),
    .element_index  (element_index),
    .block_last     (block_last),
    .total_elements (total_elements)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor. It takes one accepted transaction and queues the result that
  // it causes, if any. Header bytes always arrive most significant first;
  // payload bytes are placed by the byte order in force when each arrives.
  // --------------------------------------------------------------------------
  function automatic void deframe_byte(input logic op, input logic [7:0] b);
    deframe_result_t res;
    res = '{kind: KIND_WORD, word: '0, elem_index: '0, blk_last: 1'b0, total: '0};
    if (op == OP_CLOSE) begin
      // A close reports the committed total and wipes all framing state,
      // but the byte order register keeps its value.
      res.kind = KIND_ABORT;
      res.total = total_committed;
      awaited_results.push_back(res);
      in_block = 1'b0;
      phase = 2'd0;
      assembly = '0;
      words_left = '0;
      words_done = '0;
      total_committed = '0;
      return;
    end
    if (!in_block) begin
      assembly = {assembly[23:0], b};
      phase = phase + 2'd1;
      if (phase != 2'd0) return;
      if (assembly == '0) begin
        // A zero count ends the transmission and clears the total.
        res.kind = KIND_END;
        res.total = total_committed;
        awaited_results.push_back(res);
        total_committed = '0;
      end else begin
        in_block = 1'b1;
        words_left = assembly;
        words_done = '0;
      end
      assembly = '0;
      return;
    end
    if (order_be) assembly = {assembly[23:0], b};
    else assembly = {b, assembly[31:8]};
    phase = phase + 2'd1;
    if (phase != 2'd0) return;
    res.word = assembly;
    res.elem_index = total_committed + words_done;
    res.blk_last = (words_left == 32'd1);
    awaited_results.push_back(res);
    assembly = '0;
    words_done = words_done + 32'd1;
    words_left = words_left - 32'd1;
    if (words_left == '0) begin
      // The block is committed only once its last word has been seen.
      total_committed = total_committed + words_done;
      words_done = '0;
      in_block = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Inputs change on the falling edge. A random gap is drawn for every
  // transaction unless sender idling is off. The
  // task returns on the rising edge at which the transaction was accepted,
  // leaving valid high so that a following call can keep the stream dense.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = op;
    rx_byte = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    deframe_byte(op, b);
    items_sent++;
  endtask

  task automatic send_header(input logic [31:0] count);
    for (int i = 3; i >= 0; i--) send_item(OP_DATA, count[8*i +: 8]);
  endtask

  task automatic send_random_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(OP_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_close();
    send_item(OP_CLOSE, 8'($urandom_range(0, 255)));
  endtask

  // Lowers valid and waits until every awaited result has come back, then
  // lets the pipeline settle. This is also the sender's pause.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The byte order register is only written while the block is idle.
  task automatic set_byte_order(input logic be);
    wait_idle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = be;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    order_be = be;
  endtask

  // --------------------------------------------------------------------------
  // Receiver. For every result it draws a random stall, then
  // takes the result. A long hold-off requested by a test is served here,
  // counted in cycles, so that the block fills up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold != 0) begin
        out_stall = 1'b1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n != 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("mismatch in result %0d, %s: got %h, expected %h",
               results_seen, what, got, want);
  endtask

  // Results are sampled on the rising edge at which they are accepted.
  task automatic check_result();
    deframe_result_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with none awaited, kind", 32'(kind), 32'd0);
      return;
    end
    want = awaited_results.pop_front();
    if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
    if (word_value !== want.word) report_mismatch("word_value", word_value, want.word);
    if (element_index !== want.elem_index)
      report_mismatch("element_index", element_index, want.elem_index);
    if (block_last !== want.blk_last)
      report_mismatch("block_last", 32'(block_last), 32'(want.blk_last));
    if (total_elements !== want.total)
      report_mismatch("total_elements", total_elements, want.total);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) check_result();
  end

  // Watchdog: counts cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("timeout: nothing accepted for %0d cycles", QuietLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and every kind of result: a one-word block of all ones,
  // the end of a transmission with a nonzero total, a close that carries
  // stray byte bits, a close in the middle of a header and a close that drops
  // a partial block.
  task automatic test_directed();
    send_header(32'd1);
    for (int i = 0; i < 4; i++) send_item(OP_DATA, 8'hFF);
    send_header(32'd0);
    send_item(OP_CLOSE, 8'hFF);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h00);
    send_item(OP_CLOSE, 8'h00);
    send_header(32'd2);
    send_item(OP_DATA, 8'hA5);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_DATA, 8'h3C);
    send_item(OP_DATA, 8'hC3);
    send_close();
  endtask

  // Big-endian payload words, then the byte order changed in mid-word so
  // that the two halves of one word are placed under different settings.
  task automatic test_byte_order();
    set_byte_order(1'b1);
    send_header(32'd2);
    send_item(OP_DATA, 8'h12);
    send_item(OP_DATA, 8'h34);
    send_item(OP_DATA, 8'h56);
    send_item(OP_DATA, 8'h78);
    send_item(OP_DATA, 8'h9A);
    send_item(OP_DATA, 8'hBC);
    set_byte_order(1'b0);
    send_item(OP_DATA, 8'hDE);
    send_item(OP_DATA, 8'hF0);
    send_header(32'd0);
  endtask

  // A committed block followed by a header of the largest count; the close
  // must report only the committed words.
  task automatic test_huge_count();
    send_header(32'd3);
    send_random_bytes(12);
    send_header(32'hFFFF_FFFF);
    send_random_bytes(9);
    send_close();
  endtask

  // The receiver holds off for a long stretch while the sender streams
  // without gaps, so the internal queue fills and the input is stalled.
  task automatic test_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold = 200;
    for (int i = 0; i < 5; i++) begin
      send_header(32'd4);
      send_random_bytes(16);
    end
    send_header(32'd0);
    wait_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Mostly well-formed blocks with random words, mixed with ends of
  // transmission, closes, truncated blocks, huge counts and raw noise. The
  // byte order is changed now and then between blocks.
  task automatic test_random_stream();
    int unsigned start;
    int unsigned last_cfg;
    int unsigned pick;
    int unsigned count;
    start = items_sent;
    last_cfg = items_sent;
    while (items_sent - start < 1500) begin
      if (items_sent - last_cfg >= 250) begin
        set_byte_order(1'($urandom_range(0, 1)));
        last_cfg = items_sent;
      end
      // Idling is switched off for some stretches on either side.
      tx_idle_on = ($urandom_range(0, 5) != 0);
      rx_idle_on = ($urandom_range(0, 5) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        send_header(count);
        send_random_bytes(4 * count);
      end else if (pick < 80) begin
        send_header(32'd0);
      end else if (pick < 86) begin
        send_close();
      end else if (pick < 93) begin
        // A block cut short by the peer closing the connection.
        count = $urandom_range(1, 8);
        send_header(count);
        send_random_bytes($urandom_range(0, 4 * count - 1));
        send_close();
      end else if (pick < 97) begin
        send_header({8'($urandom_range(1, 255)), 24'($urandom)});
        send_random_bytes($urandom_range(0, 12));
        send_close();
      end else begin
        // Raw noise, after which a close brings the stream back in frame.
        send_random_bytes($urandom_range(1, 10));
        send_close();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_byte_order();
    test_huge_count();
    test_backpressure();
    test_random_stream();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
